/* rtl/kflerp_pkg.sv */
// Package: shared types, constants and a saturation function for the keyframe lerp sampler.
`timescale 1ns / 1ps
package kflerp_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = KEY_AW + 1;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic signed [32:0] MIN_GAP = 33'sd7;

    // Quotient bits: |num| is up to 33 bits, shifted left by 16.
    localparam int DIV_W   = 49;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic CFG_KEY_COUNT = 1'b0;
    localparam logic CFG_EMPTY_DEF = 1'b1;

    typedef struct packed {
        logic               func;
        logic [5:0]         key_slot;
        logic signed [31:0] key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] sample_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out;

    typedef struct packed {
        logic signed [31:0] t;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_key;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/keyframe_vec3_lerp_sampler.sv */
// Top level: keyframe table with a serial divider and shared multiplier for lerp.
`timescale 1ns / 1ps
// Keyframe sampler, linear interpolation of x, y and z in signed Q16.16.
// Input channel (i_in_valid / o_in_ready) carries load and sample beats.
// A load beat writes one table slot in the cycle it is accepted and gives
// no result. A sample beat gives exactly one result beat on the output
// channel (o_out_valid / i_out_ready).
// A sample walks the key times with a read state and a compare state per key (one memory
// read port), rereads the two chosen keys, runs a restoring divider at one quotient bit
// per cycle and then one shared multiplier over the three components (a difference,
// a multiply and an accumulate step each). An early hit ends the walk, a gap under the
// minimum skips the divider, a single key skips the walk and an empty table goes
// straight to the output step.
// The input is not ready while a sample is in work.
// The result sits in an output register; the block takes the next beat
// while it waits, and only stalls at the end of the next sample if it has
// still not been taken.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// the configuration (key_count 0, empty_default 0). The table is not
// cleared; only slots that were loaded may be sampled.
// Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must make
// them only while the block is idle, which the block itself does not enforce.
module keyframe_vec3_lerp_sampler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  kflerp_pkg::t_in       i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output kflerp_pkg::t_out      o_out_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [6:0]            i_cfg_wdata
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SRD  = 12'b0000_0000_0010,
        S_SCMP = 12'b0000_0000_0100,
        S_RA   = 12'b0000_0000_1000,
        S_RB   = 12'b0000_0001_0000,
        S_CB   = 12'b0000_0010_0000,
        S_PREP = 12'b0000_0100_0000,
        S_DIV  = 12'b0000_1000_0000,
        S_FIX  = 12'b0001_0000_0000,
        S_DIFF = 12'b0010_0000_0000,
        S_MUL  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    localparam int AW = kflerp_pkg::KEY_AW;

    kflerp_pkg::t_key r_mem [kflerp_pkg::MAX_KEYS];
    kflerp_pkg::t_key r_rdata;
    logic [AW-1:0]    rd_addr;

    t_state r_state, n_state;

    logic [kflerp_pkg::CNT_W-1:0] r_key_count;
    logic                         r_empty_def;

    logic signed [31:0] r_t;
    logic [AW-1:0]      r_i, r_last, r_idx;
    logic [AW-1:0]      nxt;
    kflerp_pkg::t_key   r_a, r_b;
    logic signed [32:0] r_delta, r_num;
    logic [32:0]        r_rem;
    logic [kflerp_pkg::DIV_W-1:0] r_dq;
    logic [kflerp_pkg::DCNT_W-1:0] r_dcnt;
    logic               r_neg;
    logic signed [31:0] r_factor;
    logic [1:0]         r_c;
    logic               r_phase;
    logic signed [32:0] r_diff;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_res [3];
    logic               r_out_valid;
    kflerp_pkg::t_out   r_out;

    logic                          in_acc;
    logic [kflerp_pkg::CNT_W-1:0]  n_keys;
    logic [33:0]                   rem_sh;
    logic signed [49:0]            q_s;
    logic signed [31:0]            comp_a, comp_b;
    logic signed [49:0]            acc;
    logic [32:0]                   num_mag;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign n_keys = (r_key_count > kflerp_pkg::CNT_W'(kflerp_pkg::MAX_KEYS))
                  ? kflerp_pkg::CNT_W'(kflerp_pkg::MAX_KEYS) : r_key_count;
    assign nxt    = (r_idx == r_last) ? r_last : r_idx + 1'b1;
    assign rem_sh = {r_rem, r_dq[kflerp_pkg::DIV_W-1]};
    assign q_s    = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign num_mag = r_num[32] ? 33'(-r_num) : 33'(r_num);
    assign acc    = 50'(comp_a) + 50'(r_prod >>> 16);

    always_comb begin
        unique case (r_c)
            2'd0:    begin comp_a = r_a.x; comp_b = r_b.x; end
            2'd1:    begin comp_a = r_a.y; comp_b = r_b.y; end
            default: begin comp_a = r_a.z; comp_b = r_b.z; end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_RA:    rd_addr = r_idx;
            S_RB:    rd_addr = nxt;
            default: rd_addr = r_i;
        endcase
    end

    // Table memory: one write port (load beats), one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.func == kflerp_pkg::FUNC_LOAD) begin
            r_mem[i_in_data.key_slot[AW-1:0]] <= '{t: i_in_data.key_time,
                x: i_in_data.value_x, y: i_in_data.value_y, z: i_in_data.value_z};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_empty_def <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kflerp_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_wdata;
                default:                   r_empty_def <= i_cfg_wdata[0];
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.func == kflerp_pkg::FUNC_SAMPLE) begin
                    if (n_keys == '0) begin
                        n_state = S_OUT;
                    end else if (n_keys == kflerp_pkg::CNT_W'(1)) begin
                        n_state = S_RA;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD:  n_state = S_SCMP;
            S_SCMP: begin
                if (r_t < r_rdata.t || r_i == r_last) begin
                    n_state = S_RA;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_RA:   n_state = S_RB;
            S_RB:   n_state = S_CB;
            S_CB:   n_state = S_PREP;
            S_PREP: n_state = (r_delta < kflerp_pkg::MIN_GAP) ? S_DIFF : S_DIV;
            S_DIV:  n_state = (r_dcnt == kflerp_pkg::DCNT_W'(1)) ? S_FIX : S_DIV;
            S_FIX:  n_state = S_DIFF;
            S_DIFF: n_state = S_MUL;
            S_MUL: begin
                if (r_phase && r_c == 2'd2) begin
                    n_state = S_OUT;
                end else if (r_phase) begin
                    n_state = S_DIFF;
                end
            end
            S_OUT:  n_state = (!r_out_valid || i_out_ready) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: search, key capture, divider, shared multiplier and output register.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_t     <= i_in_data.sample_time;
                r_last  <= AW'(n_keys - 1'b1);
                r_i     <= AW'(1);
                r_idx   <= '0;
                r_c     <= '0;
                r_phase <= 1'b0;
                r_res[0] <= r_empty_def ? $signed(kflerp_pkg::ONE_Q16) : '0;
                r_res[1] <= r_empty_def ? $signed(kflerp_pkg::ONE_Q16) : '0;
                r_res[2] <= r_empty_def ? $signed(kflerp_pkg::ONE_Q16) : '0;
            end
            S_SCMP: begin
                if (r_t < r_rdata.t) begin
                    r_idx <= r_i - 1'b1;
                end else if (r_i == r_last) begin
                    r_idx <= r_last;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_RB: r_a <= r_rdata;
            S_CB: begin
                r_b      <= r_rdata;
                r_delta  <= 33'(r_rdata.t) - 33'(r_a.t);
                r_num    <= 33'(r_t) - 33'(r_a.t);
                r_factor <= '0;
            end
            S_PREP: begin
                r_rem  <= '0;
                r_dq   <= {num_mag, 16'h0000};
                r_neg  <= r_num[32];
                r_dcnt <= kflerp_pkg::DCNT_W'(kflerp_pkg::DIV_W);
            end
            S_DIV: begin
                // One restoring step: shift in a dividend bit, try subtract.
                if (rem_sh >= {1'b0, r_delta}) begin
                    r_rem <= 33'(rem_sh - {1'b0, r_delta});
                    r_dq  <= {r_dq[kflerp_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[32:0];
                    r_dq  <= {r_dq[kflerp_pkg::DIV_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_FIX:  r_factor <= kflerp_pkg::sat32(q_s);
            S_DIFF: r_diff <= 33'(comp_b) - 33'(comp_a);
            S_MUL: begin
                if (!r_phase) begin
                    r_prod <= 65'(r_diff) * 65'(r_factor);
                end else begin
                    r_res[r_c] <= kflerp_pkg::sat32(acc);
                    r_c        <= r_c + 1'b1;
                end
                r_phase <= !r_phase;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= '{out_x: r_res[0], out_y: r_res[1], out_z: r_res[2]};
                end
            end
            default: ;
        endcase
    end

    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.func == kflerp_pkg::FUNC_SAMPLE |=> !o_in_ready)
        else $error("sample beat accepted but input still ready");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output step");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCMP |-> r_i <= r_last && r_i != '0)
        else $error("search index out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dcnt != '0)
        else $error("divider ran past its last step");

endmodule
